// ===== rtl/core/mecodo_pkg.sv =====
// ----------------------------------------------------------------------------
// Mecanum odometry package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mecodo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_ENTRIES     = 31;
  localparam logic [15:0] GAIN_RST         = 16'd7620;
  localparam logic [3:0]  MASK_RST         = 4'd10;
  localparam logic [31:0] CORDIC_K         = 32'd652032874;
  localparam logic [31:0] HALF_TURN        = 32'h8000_0000;
  localparam logic signed [33:0] QUARTER   = 34'sd1073741824;

  localparam logic [1:0] FUNC_ENC  = 2'd0;
  localparam logic [1:0] FUNC_IMU  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [0:0] REG_GAIN = 1'b0;
  localparam logic [0:0] REG_MASK = 1'b1;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] wheel_speed_0;
    logic signed [15:0] wheel_speed_1;
    logic signed [15:0] wheel_speed_2;
    logic signed [15:0] wheel_speed_3;
    logic [19:0]        elapsed_us;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic signed [15:0] half_yaw_cos;
    logic signed [15:0] half_yaw_sin;
    logic signed [31:0] heading;
  } out_beat_t;

  // CORDIC command/status between sequencer and engine
  typedef struct packed {
    logic        start;
    logic        vectoring;
    logic [31:0] angle;
    logic signed [33:0] vx;
    logic signed [33:0] vy;
  } cordic_cmd_t;

  typedef struct packed {
    logic               done;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic [31:0]        z;
  } cordic_rsp_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      5'd28: r = 32'd3;         5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/mecanum_odometry_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// Mecanum odometry integrator
// Dead-reckoning pose from wheel speeds and IMU yaw.
// ----------------------------------------------------------------------------
// in_* carries one beat per item; func picks encoder, IMU or tick. Encoder
// beats store the forward and sideways step, IMU beats update the relative
// yaw through a CORDIC atan2, tick beats rotate the step by the yaw, add it
// to the saturating pose and send one out_* beat. Func code 3 is dropped.
// The block takes one item at a time: in_stall is high from acceptance
// until the item is finished. Encoder items use the shared multiplier;
// IMU items (but for a degenerate quaternion, which skips the CORDIC) and
// ticks, which run the CORDIC twice, use both the shared multiplier
// and the iterative CORDIC. The result sits in an output register; while
// out_stall is high it holds and further items are still taken; a tick that
// finishes meanwhile waits in its last state until the register frees.
// cfg_* writes distance_gain (index 0) or wheel_invert_mask (index 1),
// always ready; other indexes are ignored. Synchronous active-low reset
// clears pose, step, yaw, flags and restores register defaults.
// ----------------------------------------------------------------------------
module mecanum_odometry_integrator_unit #(
  parameter int unsigned CORDIC_STEPS = mecodo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mecodo_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mecodo_pkg::out_beat_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMIX  = 4'd1;
  localparam logic [3:0] S_EM1   = 4'd2;
  localparam logic [3:0] S_EM2   = 4'd3;
  localparam logic [3:0] S_IQ    = 4'd4;
  localparam logic [3:0] S_IWAIT = 4'd5;
  localparam logic [3:0] S_TWAIT = 4'd6;
  localparam logic [3:0] S_TM    = 4'd7;
  localparam logic [3:0] S_TACC  = 4'd8;
  localparam logic [3:0] S_HWAIT = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_IM    = 4'd11;

  logic [3:0]  st_r, st_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [15:0] gain_r;
  logic [3:0]  mask_r;
  mecodo_pkg::in_beat_t in_r;
  logic signed [63:0] xa_r, xa_nxt, ya_r, ya_nxt;
  logic signed [39:0] sf_r, sf_nxt, ss_r, ss_nxt;
  logic [31:0] yaw_r, yaw_nxt, off_r, off_nxt;
  logic        took_r, took_nxt, seen_r, seen_nxt;
  logic signed [63:0] acc_r, acc_nxt;       // shared product accumulator
  logic signed [33:0] c22_r, c22_nxt, s22_r, s22_nxt;
  logic signed [33:0] num_r, num_nxt;
  logic signed [18:0] fsum_r, fsum_nxt, ssum_r, ssum_nxt;
  logic [15:0] hc_r, hc_nxt, hs_r, hs_nxt;
  logic        ov_r, ov_nxt;
  mecodo_pkg::out_beat_t ob_r, ob_nxt;

  logic signed [39:0] ma;       // shared multiplier operands
  logic signed [23:0] mb;
  logic signed [63:0] mp;
  mecodo_pkg::cordic_cmd_t cmd;
  mecodo_pkg::cordic_rsp_t rsp;
  logic flip;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;

  mecodo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp)
  );

  assign mp = ma * mb;

  // yaw outside a quarter turn either way: rotate by a half turn less, negate
  assign flip = ($signed({{2{yaw_r[31]}}, yaw_r}) > mecodo_pkg::QUARTER) ||
                ($signed({{2{yaw_r[31]}}, yaw_r}) < -mecodo_pkg::QUARTER);

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic [15:0] to_q15(input logic signed [33:0] v);
    logic signed [33:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) return 16'h7fff;
    if (r < -34'sd32768) return 16'h8000;
    return r[15:0];
  endfunction

  logic signed [16:0] w0, w1, w2, w3;
  logic signed [31:0] ysg;
  always_comb begin
    w0 = mask_r[0] ? -{in_r.wheel_speed_0[15], in_r.wheel_speed_0}
                   : {in_r.wheel_speed_0[15], in_r.wheel_speed_0};
    w1 = mask_r[1] ? -{in_r.wheel_speed_1[15], in_r.wheel_speed_1}
                   : {in_r.wheel_speed_1[15], in_r.wheel_speed_1};
    w2 = mask_r[2] ? -{in_r.wheel_speed_2[15], in_r.wheel_speed_2}
                   : {in_r.wheel_speed_2[15], in_r.wheel_speed_2};
    w3 = mask_r[3] ? -{in_r.wheel_speed_3[15], in_r.wheel_speed_3}
                   : {in_r.wheel_speed_3[15], in_r.wheel_speed_3};
    ysg = yaw_r;
  end

  // sequence one item through the shared multiplier and CORDIC
  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r;
    xa_nxt = xa_r; ya_nxt = ya_r; sf_nxt = sf_r; ss_nxt = ss_r;
    yaw_nxt = yaw_r; off_nxt = off_r; took_nxt = took_r; seen_nxt = seen_r;
    acc_nxt = acc_r; c22_nxt = c22_r; s22_nxt = s22_r; num_nxt = num_r;
    fsum_nxt = fsum_r; ssum_nxt = ssum_r; ob_nxt = ob_r;
    hc_nxt = hc_r; hs_nxt = hs_r;
    ov_nxt = ov_r && out_stall;
    ma = '0; mb = '0;
    cmd = '0;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data.func)
            mecodo_pkg::FUNC_ENC:  st_nxt = S_EMIX;
            mecodo_pkg::FUNC_IMU:  begin st_nxt = S_IQ; ph_nxt = 3'd0; end
            mecodo_pkg::FUNC_TICK: begin
              st_nxt = S_TWAIT;
              cmd.start = 1'b1;
              cmd.angle = yaw_r;
              if (flip)
                cmd.angle = yaw_r - mecodo_pkg::HALF_TURN;
            end
            default: st_nxt = S_IDLE;
          endcase
        end
      end
      S_EMIX: begin
        fsum_nxt = 19'(w0) + 19'(w1) + 19'(w2) + 19'(w3);
        ssum_nxt = -19'(w0) + 19'(w1) + 19'(w2) - 19'(w3);
        st_nxt = S_EM1; ph_nxt = 3'd0;
      end
      S_EM1: begin
        // gain*dt first, then times each sum
        ma = 40'($signed({1'b0, gain_r}));
        mb = seen_r ? 24'($signed({1'b0, in_r.elapsed_us})) : 24'sd0;
        acc_nxt = mp;
        seen_nxt = 1'b1;
        st_nxt = S_EM2; ph_nxt = 3'd0;
      end
      S_EM2: begin
        ma = acc_r[39:0];
        mb = ph_r[0] ? 24'(ssum_r) : 24'(fsum_r);
        if (ph_r[0]) begin
          ss_nxt = 40'((mp + 64'sd32768) >>> 16);
          st_nxt = S_IDLE;
        end else begin
          sf_nxt = 40'((mp + 64'sd32768) >>> 16);
          ph_nxt = 3'd1;
        end
      end
      S_IQ: begin
        // four products: wz, xy, yy, zz
        case (ph_r)
          3'd0: begin ma = 40'(in_r.quat_w); mb = 24'(in_r.quat_z); end
          3'd1: begin ma = 40'(in_r.quat_x); mb = 24'(in_r.quat_y); end
          3'd2: begin ma = 40'(in_r.quat_y); mb = 24'(in_r.quat_y); end
          default: begin ma = 40'(in_r.quat_z); mb = 24'(in_r.quat_z); end
        endcase
        case (ph_r)
          3'd0: acc_nxt = mp;
          3'd1: begin
            num_nxt = 34'((acc_r + mp) <<< 1);
            acc_nxt = '0;
          end
          3'd2: acc_nxt = mp;
          default: acc_nxt = acc_r + mp;
        endcase
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd3) st_nxt = S_IM;
      end
      S_IM: begin
        if (num_r == '0 && acc_r == 64'sd536870912) begin
          yaw_nxt = 32'd0 - off_r;
          st_nxt = S_IDLE;
          if (!took_r && yaw_r != 32'd0) begin
            off_nxt = 32'd0; took_nxt = 1'b1; yaw_nxt = 32'd0;
          end
        end else begin
          cmd.start = 1'b1;
          cmd.vectoring = 1'b1;
          cmd.vy = num_r;
          cmd.vx = 34'(64'sd1073741824 - (acc_r <<< 1));
          st_nxt = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (rsp.done) begin
          st_nxt = S_IDLE;
          if (!took_r && yaw_r != 32'd0) begin
            off_nxt = rsp.z; took_nxt = 1'b1; yaw_nxt = 32'd0;
          end else begin
            yaw_nxt = rsp.z - off_r;
          end
        end
      end
      S_TWAIT: begin
        if (rsp.done) begin
          if (flip) begin
            c22_nxt = (-rsp.x + 34'sd128) >>> 8;
            s22_nxt = (-rsp.y + 34'sd128) >>> 8;
          end else begin
            c22_nxt = (rsp.x + 34'sd128) >>> 8;
            s22_nxt = (rsp.y + 34'sd128) >>> 8;
          end
          st_nxt = S_TM; ph_nxt = 3'd0;
        end
      end
      S_TM: begin
        // sf*c, ss*s, sf*s, ss*c; rounded into the pose
        case (ph_r)
          3'd0: begin ma = sf_r; mb = 24'(c22_r); end
          3'd1: begin ma = ss_r; mb = 24'(s22_r); end
          3'd2: begin ma = sf_r; mb = 24'(s22_r); end
          default: begin ma = ss_r; mb = 24'(c22_r); end
        endcase
        case (ph_r)
          3'd0: acc_nxt = mp;
          3'd1: begin
            xa_nxt = sat_add(xa_r, (acc_r - mp + 64'sd2097152) >>> 22);
          end
          3'd2: acc_nxt = mp;
          default: begin
            ya_nxt = sat_add(ya_r, (acc_r + mp + 64'sd2097152) >>> 22);
          end
        endcase
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd3) st_nxt = S_TACC;
      end
      S_TACC: begin
        cmd.start = 1'b1;
        cmd.angle = 32'(ysg >>> 1);
        st_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        if (rsp.done) begin
          hc_nxt = to_q15(rsp.x);
          hs_nxt = to_q15(rsp.y);
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // load the output register once the previous beat has left
        if (!(ov_r && out_stall)) begin
          ob_nxt.pos_x = xa_r;
          ob_nxt.pos_y = ya_r;
          ob_nxt.half_yaw_cos = hc_r;
          ob_nxt.half_yaw_sin = hs_r;
          ob_nxt.heading = yaw_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= '0;
      gain_r <= mecodo_pkg::GAIN_RST; mask_r <= mecodo_pkg::MASK_RST;
      xa_r <= '0; ya_r <= '0; sf_r <= '0; ss_r <= '0;
      yaw_r <= '0; off_r <= '0; took_r <= 1'b0; seen_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt;
      xa_r <= xa_nxt; ya_r <= ya_nxt; sf_r <= sf_nxt; ss_r <= ss_nxt;
      yaw_r <= yaw_nxt; off_r <= off_nxt; took_r <= took_nxt;
      seen_r <= seen_nxt; ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == {1'b0, mecodo_pkg::REG_GAIN}) gain_r <= cfg_data[15:0];
        else if (cfg_index == {1'b0, mecodo_pkg::REG_MASK}) mask_r <= cfg_data[3:0];
      end
    end
    if (in_acc) in_r <= in_data;
    acc_r <= acc_nxt; c22_r <= c22_nxt; s22_r <= s22_nxt; num_r <= num_nxt;
    fsum_r <= fsum_nxt; ssum_r <= ssum_nxt;
    hc_r <= hc_nxt; hs_r <= hs_nxt;
    ob_r <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = ob_r;

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result lost under stall");
  a_offset_once: assert property (@(posedge clk) disable iff (!rst_n)
    $past(took_r) |-> (took_r && $stable(off_r))) else $error("offset retaken");
`endif

endmodule

// ===== rtl/core/mecodo_cordic.sv =====
// ----------------------------------------------------------------------------
// Mecanum odometry CORDIC engine
// Iterative shift-add CORDIC, one micro-rotation per cycle, rotation or
// vectoring mode on Q2.30 operands.
// ----------------------------------------------------------------------------
module mecodo_cordic #(
  parameter int unsigned CORDIC_STEPS = mecodo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mecodo_pkg::cordic_cmd_t cmd,
  output mecodo_pkg::cordic_rsp_t rsp
);

  localparam int unsigned NIT = (CORDIC_STEPS < mecodo_pkg::ATAN_ENTRIES) ?
                                CORDIC_STEPS : mecodo_pkg::ATAN_ENTRIES;

  // x and y carry two guard bits: a vectoring input near the corner of the
  // Q2.30 range grows past 2^33 under the CORDIC gain
  logic               busy_r, busy_nxt;
  logic               mode_r, mode_nxt;
  logic [4:0]         it_r, it_nxt;
  logic signed [35:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [33:0] zs_r, zs_nxt;
  logic [31:0]        z_r, z_nxt;
  logic               done_r, done_nxt;

  logic signed [35:0] xs, ys;
  logic signed [33:0] at;
  logic               dir;

  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign at = $signed({2'b00, mecodo_pkg::atan_lut(it_r)});
  // vectoring drives y to zero, rotation drives the residual angle to zero
  assign dir = mode_r ? (y_r > 36'sd0) : (zs_r < 34'sd0);

  // advance one micro-rotation per cycle
  always_comb begin
    busy_nxt = busy_r;
    mode_nxt = mode_r;
    it_nxt   = it_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    zs_nxt   = zs_r;
    z_nxt    = z_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      mode_nxt = cmd.vectoring;
      it_nxt   = 5'd0;
      if (cmd.vectoring) begin
        z_nxt = 32'd0;
        if (cmd.vx < 0) begin
          x_nxt = -36'(cmd.vx);
          y_nxt = -36'(cmd.vy);
          z_nxt = mecodo_pkg::HALF_TURN;
        end else begin
          x_nxt = 36'(cmd.vx);
          y_nxt = 36'(cmd.vy);
        end
        zs_nxt = '0;
      end else begin
        x_nxt  = $signed({4'b0000, mecodo_pkg::CORDIC_K});
        y_nxt  = '0;
        zs_nxt = {{2{cmd.angle[31]}}, cmd.angle};
        z_nxt  = '0;
      end
    end else if (busy_r) begin
      if (mode_r) begin
        if (dir) begin
          x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + at[31:0];
        end else begin
          x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - at[31:0];
        end
      end else begin
        if (!dir) begin
          x_nxt = x_r - ys; y_nxt = y_r + xs; zs_nxt = zs_r - at;
        end else begin
          x_nxt = x_r + ys; y_nxt = y_r - xs; zs_nxt = zs_r + at;
        end
      end
      it_nxt = it_r + 5'd1;
      if (it_r == 5'(NIT - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      it_r   <= it_nxt;
    end
    mode_r <= mode_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    zs_r   <= zs_nxt;
    z_r    <= z_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.x    = x_r[33:0];
  assign rsp.y    = y_r[33:0];
  assign rsp.z    = z_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !cmd.start) else $error("cordic restarted while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("cordic done while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("cordic done held");
`endif

endmodule
